@@ rtl/extent_leaf_block_map_assert.svh @@
// assertion macros for the extent leaf block map
`ifndef EXTENT_LEAF_BLOCK_MAP_ASSERT_SVH
`define EXTENT_LEAF_BLOCK_MAP_ASSERT_SVH

`ifndef SYNTHESIS

`define ELBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ELBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ELBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define ELBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/elbm_pkg.sv @@
// shared types, widths and codes of the extent leaf block map
package elbm_pkg;

  localparam int MAX_EXTENTS_DEF = 4;

  localparam int FIRST_W = 32;
  localparam int QUERY_W = 32;
  localparam int LEN_W   = 16;
  localparam int START_W = 48;
  localparam int PHYS_W  = 49;

  localparam logic [LEN_W-1:0] UNINIT_BIAS = 16'd32768;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_MAPPED = 2'd0;
  localparam logic [1:0] STATUS_NOMAP  = 2'd1;
  localparam logic [1:0] STATUS_OK     = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [FIRST_W-1:0] ext_first_block;
    logic [LEN_W-1:0]   ext_length_raw;
    logic [START_W-1:0] ext_start_block;
    logic [QUERY_W-1:0] query_block;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PHYS_W-1:0] physical_block;
  } rsp_t;

  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [LEN_W-1:0]   length;
    logic [START_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] offset;
  } match_t;

endpackage

@@ rtl/elbm_if.sv @@
// request and response channel interfaces of the extent leaf block map
interface elbm_req_if;
  import elbm_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface elbm_rsp_if;
  import elbm_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/elbm_range_unit.sv @@
// shared range compare unit: does one entry cover the query block
module elbm_range_unit (
  input  elbm_pkg::entry_t                   entry,
  input  logic [elbm_pkg::QUERY_W-1:0]       query,
  output elbm_pkg::match_t                   match
);
  import elbm_pkg::*;

  logic [QUERY_W:0] diff;

  // no wrap: borrow out means query below first
  assign diff = {1'b0, query} - {1'b0, entry.first};

  assign match.hit = !diff[QUERY_W] && (diff[QUERY_W-1:LEN_W] == '0) &&
                     (diff[LEN_W-1:0] < entry.length);
  assign match.offset = diff[LEN_W-1:0];

endmodule

@@ rtl/extent_leaf_block_map.sv @@
// extent leaf table with logical to physical block translation
//
// Holds up to MAX_EXTENTS extent entries in an on-chip table and answers one command per
// transfer. Clear, append and the unused command go from idle to the response state, which
// loads the result register and returns to idle once the output is free. A lookup tests the
// entries in order up to and including the first hit (all entry_count entries on a miss,
// none on an empty table), since one shared range compare unit checks one table entry per
// cycle as it streams out of the table's single read port. A hit passes through a sum state
// for the 49-bit start plus offset sum. The result register is loaded in the same cycle as
// the return to idle, when the request side is ready again. The request side is not
// ready while a command is at work; a finished result sits in the output register, so the
// next command is taken while it waits.
`include "extent_leaf_block_map_assert.svh"

module extent_leaf_block_map #(
  parameter int MAX_EXTENTS = elbm_pkg::MAX_EXTENTS_DEF
) (
  input logic       clk,
  input logic       rst,
  elbm_req_if.sink  req,
  elbm_rsp_if.source rsp
);
  import elbm_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EXTENTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TEST = 4'b0010,
    S_SUM  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic [QUERY_W-1:0] query;
  entry_t             mem [MAX_EXTENTS];
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic [IDX_W-1:0]   rd_addr;
  logic [LEN_W-1:0]   len_in;
  logic [1:0]         pend_status;
  logic [PHYS_W-1:0]  pend_phys;
  logic [START_W-1:0] hit_start;
  logic [LEN_W-1:0]   hit_offset;
  logic               rsp_valid;
  rsp_t               rsp_data;
  match_t             match;
  logic               accept;
  logic               full;
  logic               wr_en;
  logic               slot_free;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_MAX);
  assign wr_en     = accept && (req.data.cmd == CMD_APPEND) && !full;
  assign slot_free = !rsp_valid || rsp.ready;

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // uninitialised extents carry the bias in the raw length
  assign len_in = (req.data.ext_length_raw > UNINIT_BIAS) ?
                  req.data.ext_length_raw - UNINIT_BIAS : req.data.ext_length_raw;

  assign wr_entry.first  = req.data.ext_first_block;
  assign wr_entry.length = len_in;
  assign wr_entry.start  = req.data.ext_start_block;

  assign rd_addr = (state == S_IDLE || ptr == CNT_MAX) ? '0 : ptr[IDX_W-1:0];

  elbm_range_unit u_range (
    .entry (rd_entry),
    .query (query),
    .match (match)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.data.cmd == CMD_LOOKUP && count != '0) begin
            state_next = S_TEST;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_TEST: begin
        if (match.hit) begin
          state_next = S_SUM;
        end else if (ptr == count) begin
          state_next = S_RESP;
        end
      end
      S_SUM: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && req.data.cmd == CMD_CLEAR) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CNT_W'(1);
      end
      if (state == S_RESP && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query     <= req.data.query_block;
      ptr       <= CNT_W'(1);
      pend_phys <= '0;
      case (req.data.cmd)
        CMD_LOOKUP: pend_status <= STATUS_NOMAP;
        CMD_APPEND: pend_status <= full ? STATUS_FULL : STATUS_OK;
        default:    pend_status <= STATUS_OK;
      endcase
    end
    if (state == S_TEST) begin
      if (match.hit) begin
        hit_start  <= rd_entry.start;
        hit_offset <= match.offset;
      end else if (ptr != count) begin
        ptr <= ptr + CNT_W'(1);
      end
    end
    if (state == S_SUM) begin
      pend_status <= STATUS_MAPPED;
      pend_phys   <= {{(PHYS_W-START_W){1'b0}}, hit_start} +
                     {{(PHYS_W-LEN_W){1'b0}}, hit_offset};
    end
    if (state == S_RESP && slot_free) begin
      rsp_data.status         <= pend_status;
      rsp_data.physical_block <= pend_phys;
    end
  end

  `ELBM_ASSERT_IMPL(a_count_range, clk, rst, 1'b1, count <= CNT_MAX,
                    "entry count beyond table depth")
  `ELBM_ASSERT_IMPL(a_ptr_range, clk, rst, state == S_TEST, (ptr != '0) && (ptr <= count),
                    "scan pointer outside written entries")
  `ELBM_ASSERT_NEXT(a_full_drop, clk, rst, accept && (req.data.cmd == CMD_APPEND) && full,
                    $stable(count), "append to full table changed count")
  `ELBM_ASSERT_NEXT(a_clear, clk, rst, accept && (req.data.cmd == CMD_CLEAR), count == '0,
                    "clear left entries in table")
  `ELBM_ASSERT_IMPL(a_sum_after_hit, clk, rst, state == S_SUM, $past(state) == S_TEST,
                    "sum stage entered without a hit")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the extent leaf block map: directed and random commands
`timescale 1ns / 100ps

module testbench;
  import elbm_pkg::*;

  localparam int TABLE_DEPTH = MAX_EXTENTS_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 20;
  localparam int TOTAL_ITEMS = 900;

  logic clk = 1'b0;
  logic rst;

  elbm_req_if req_ch ();
  elbm_rsp_if rsp_ch ();

  extent_leaf_block_map u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  bit [FIRST_W-1:0] table_first [TABLE_DEPTH];
  bit [LEN_W-1:0]   table_len   [TABLE_DEPTH];
  bit [START_W-1:0] table_start [TABLE_DEPTH];
  int               table_count;

  rsp_t awaited_rsp [$];
  int   mismatches;
  int   items_sent;
  bit   idling;
  int   hold_requests;
  int   hold_served;
  int   hold_left;
  int   quiet_cycles;

  // next response of the block for one accepted command, with the table kept in step
  function automatic rsp_t translate_cmd(input req_t item);
    rsp_t r;
    bit [LEN_W-1:0] len;
    bit [FIRST_W:0] q;
    bit [FIRST_W:0] lo;
    bit [FIRST_W:0] hi;
    r.status = STATUS_OK;
    r.physical_block = '0;
    case (item.cmd)
      CMD_CLEAR: table_count = 0;
      CMD_APPEND: begin
        if (table_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          len = item.ext_length_raw;
          if (len > UNINIT_BIAS) len = len - UNINIT_BIAS;
          table_first[table_count] = item.ext_first_block;
          table_len[table_count]   = len;
          table_start[table_count] = item.ext_start_block;
          table_count++;
        end
      end
      CMD_LOOKUP: begin
        r.status = STATUS_NOMAP;
        q = {1'b0, item.query_block};
        for (int i = 0; i < table_count; i++) begin
          lo = {1'b0, table_first[i]};
          hi = lo + (FIRST_W+1)'(table_len[i]);
          if (r.status == STATUS_NOMAP && q >= lo && q < hi) begin
            r.status = STATUS_MAPPED;
            r.physical_block = {1'b0, table_start[i]} + PHYS_W'(q - lo);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit [START_W-1:0] rand_start();
    bit [63:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(7) == 0) v = {16'h0, {START_W{1'b1}}} - $urandom_range(40000);
    return v[START_W-1:0];
  endfunction

  function automatic req_t rand_item();
    req_t item;
    item.cmd = 2'($urandom_range(3));
    item.ext_first_block = $urandom;
    item.ext_length_raw = 16'($urandom_range(16'hFFFF));
    item.ext_start_block = rand_start();
    item.query_block = $urandom;
    return item;
  endfunction

  function automatic req_t make_item(input logic [1:0] cmd, input bit [FIRST_W-1:0] first,
                                     input bit [LEN_W-1:0] len, input bit [START_W-1:0] start,
                                     input bit [QUERY_W-1:0] query);
    req_t item;
    item = rand_item();
    item.cmd = cmd;
    if (cmd == CMD_APPEND) begin
      item.ext_first_block = first;
      item.ext_length_raw = len;
      item.ext_start_block = start;
    end
    if (cmd == CMD_LOOKUP) item.query_block = query;
    return item;
  endfunction

  function automatic bit [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'd32769;
      3: return 16'hFFFF;
      4: return 16'd1;
      5, 6: return 16'($urandom_range(1, 64));
      7: return 16'(32768 + $urandom_range(1, 64));
      8: return 16'($urandom_range(16'hFFFF));
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  task automatic send_cmd(input req_t item);
    while (idling && $urandom_range(99) < 18) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    awaited_rsp.push_back(translate_cmd(item));
    items_sent++;
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_item(CMD_UNUSED, 0, 0, 0, 0));
    send_cmd(make_item(CMD_APPEND, 32'd0, 16'd0, 48'd0, 0));
    send_cmd(make_item(CMD_APPEND, 32'd100, 16'd32768, {START_W{1'b1}}, 0));
    send_cmd(make_item(CMD_APPEND, 32'hFFFF_FFF0, 16'hFFFF, 48'd1000, 0));
    send_cmd(make_item(CMD_APPEND, 32'd200, 16'd5, 48'd0, 0));
    send_cmd(make_item(CMD_APPEND, 32'd7, 16'd9, 48'd77, 0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd100));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd32867));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd32868));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd204));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd99));
    send_cmd(make_item(CMD_CLEAR, 0, 0, 0, 0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd100));
    send_cmd(make_item(CMD_APPEND, 32'd0, 16'd32769, 48'd5, 0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd1));
    send_cmd(make_item(CMD_UNUSED, 0, 0, 0, 0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'd0));
    send_cmd(make_item(CMD_APPEND, 32'hFFFF_FFFF, 16'd1, 48'd0, 0));
    send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF));
  endtask

  // mostly a clear first, then a few appends, then lookups mostly in or at the edges of what was appended
  task automatic run_sequence();
    bit [FIRST_W-1:0] seq_first [8];
    int               seq_len   [8];
    bit [FIRST_W-1:0] base;
    bit [FIRST_W-1:0] q;
    bit [LEN_W-1:0]   raw;
    int               n;
    int               idx;
    n = $urandom_range(1, 6);
    if ($urandom_range(9) != 0) send_cmd(make_item(CMD_CLEAR, 0, 0, 0, 0));
    case ($urandom_range(2))
      0: base = 32'hFFFF_FFFF - $urandom_range(200);
      1: base = $urandom_range(500);
      default: base = $urandom;
    endcase
    for (int i = 0; i < n; i++) begin
      raw = pick_length();
      seq_first[i] = base + $urandom_range(300);
      seq_len[i] = int'((raw > UNINIT_BIAS) ? raw - UNINIT_BIAS : raw);
      send_cmd(make_item(CMD_APPEND, seq_first[i], raw, rand_start(), 0));
    end
    repeat ($urandom_range(4, 10)) begin
      idx = $urandom_range(n - 1);
      case ($urandom_range(9))
        0: q = $urandom;
        1: q = seq_first[idx] - 1;
        2: q = seq_first[idx] + seq_len[idx];
        default: q = seq_first[idx] + $urandom_range(seq_len[idx] + 1);
      endcase
      send_cmd(make_item(CMD_LOOKUP, 0, 0, 0, q));
    end
  endtask

  task automatic test_sequences(input int upto);
    while (items_sent < upto) run_sequence();
  endtask

  task automatic test_hold_off();
    hold_requests++;
    repeat (3) run_sequence();
  endtask

  task automatic test_pause();
    wait_drained();
    repeat (2) run_sequence();
  endtask

  task automatic test_noise(input int upto);
    while (items_sent < upto) send_cmd(rand_item());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(idling && $urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_rsp.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer status %0d physical_block %0h", $time,
                 rsp_ch.data.status, rsp_ch.data.physical_block);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp_ch.data.status !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_ch.data.status);
        end
        if (rsp_ch.data.physical_block !== want.physical_block) begin
          mismatches++;
          $display("%0t: physical_block expected %0h actual %0h", $time,
                   want.physical_block, rsp_ch.data.physical_block);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("** extent_leaf_block_map: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    idling = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    idling = 1'b0;
    test_sequences(350);
    idling = 1'b1;
    test_hold_off();
    test_sequences(650);
    test_pause();
    test_noise(TOTAL_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** extent_leaf_block_map: PASSED **");
    end else begin
      $display("** extent_leaf_block_map: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/elbm_pkg.sv
rtl/elbm_if.sv
rtl/elbm_range_unit.sv
rtl/extent_leaf_block_map.sv
tb/testbench.sv
